[rtl/core/thc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// thc_pkg: shared types and constants for thermistor counts to Celsius
// Fixed-point widths, the ln segment table, register indexes and the structs
// that travel between the log front end, the divider and the top level.
// ----------------------------------------------------------------------------
package thc_pkg;

  // ADC count bits that take part in the scaling
  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned X_W        = COUNT_BITS + 32;

  // Register reset values
  localparam logic [31:0] COEF_A_RST = 32'd1238158836;
  localparam logic [31:0] COEF_B_RST = 32'd258970437;
  localparam logic [31:0] COEF_C_RST = 32'd402720470;
  localparam logic [31:0] OHMS_RST   = 32'd7488001;

  // ln(2) in Q6.26, the last table entry
  localparam logic [25:0] LN_T16 = 26'd46516320;

  // Quotient limits and the output codes that saturate
  localparam logic [23:0] Q_KELVIN = 24'd2731500;
  localparam logic [23:0] Q_MAX    = 24'd5731500;
  localparam logic signed [22:0] TEMP_COLD = -23'sd2731500;
  localparam logic signed [22:0] TEMP_HOT  = 23'sd3000000;

  // (10000 << 40) >> DIV_STEPS: first partial remainder, and the sum at or
  // below which the quotient no longer fits in DIV_STEPS bits
  localparam int unsigned DIV_STEPS = 23;
  localparam logic [38:0] DIV_R0    = 39'd1310720000;

  typedef enum logic [1:0] {
    CFG_COEF_A = 2'd0,
    CFG_COEF_B = 2'd1,
    CFG_COEF_C = 2'd2,
    CFG_OHMS   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [30:0] mag;
    logic        neg;
    logic        zero;
  } ln_out_t;

  typedef struct packed {
    logic [38:0] s;
    logic        zero;
    logic        hot;
  } div_in_t;

  typedef struct packed {
    logic [38:0] r;
    logic [22:0] q;
    logic [38:0] s;
    logic        zero;
    logic        hot;
  } div_st_t;

  // ln(1 + i/16) in Q6.26
  function automatic logic [25:0] ln_tab(input logic [4:0] i);
    logic [25:0] v;
    unique case (i)
      5'd0:  v = 26'd0;
      5'd1:  v = 26'd4068450;
      5'd2:  v = 26'd7904286;
      5'd3:  v = 26'd11532676;
      5'd4:  v = 26'd14974910;
      5'd5:  v = 26'd18249163;
      5'd6:  v = 26'd21371068;
      5'd7:  v = 26'd24354175;
      5'd8:  v = 26'd27210303;
      5'd9:  v = 26'd29949820;
      5'd10: v = 26'd32581878;
      5'd11: v = 26'd35114589;
      5'd12: v = 26'd37555180;
      5'd13: v = 26'd39910118;
      5'd14: v = 26'd42185213;
      5'd15: v = 26'd44385701;
      5'd16: v = LN_T16;
      default: v = 26'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/core/thc_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// thc_if: stream interfaces for counts in and temperatures out
// Each carries valid, ready and the word; a word moves when both are high.
// ----------------------------------------------------------------------------
interface thc_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] adc_count;
  modport source (output valid, output adc_count, input ready);
  modport sink   (input valid, input adc_count, output ready);
endinterface

interface thc_out_if;
  logic               valid;
  logic               ready;
  logic signed [22:0] temp_e4;
  logic               out_of_range;
  modport source (output valid, output temp_e4, output out_of_range, input ready);
  modport sink   (input valid, input temp_e4, input out_of_range, output ready);
endinterface
`default_nettype wire

[rtl/core/thc_ln.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// thc_ln: resistance and natural log pipeline
// Six stages: scale, two normalize stages, table lookup, interpolation,
// sign and magnitude of ln(R) in Q6.26.
// ----------------------------------------------------------------------------
module thc_ln (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [thc_pkg::COUNT_BITS-1:0]   count_i,
  input  logic [31:0]                      ohms_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output thc_pkg::ln_out_t                 out_data_o
);

  localparam int unsigned N = 6;

  logic [N-1:0] v_q;
  logic [N-1:0] en;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[N-1] = !v_q[N-1] || out_ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < N; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[N-1];

  // Stage 1: scale count to ohms, Q32.32
  logic [thc_pkg::X_W-1:0] x1_q;
  always_ff @(posedge clk_i) begin
    if (en[0]) x1_q <= count_i * ohms_i;
  end

  // Stage 2: coarse normalize by 32, 16, 8
  logic [63:0] n2_d, n2_q;
  logic [5:0]  lz2_d, lz2_q;
  logic        zero2_q;
  always_comb begin
    n2_d  = 64'(x1_q);
    lz2_d = '0;
    if (n2_d[63:32] == '0) begin
      n2_d = n2_d << 32;
      lz2_d[5] = 1'b1;
    end
    if (n2_d[63:48] == '0) begin
      n2_d = n2_d << 16;
      lz2_d[4] = 1'b1;
    end
    if (n2_d[63:56] == '0) begin
      n2_d = n2_d << 8;
      lz2_d[3] = 1'b1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      n2_q    <= n2_d;
      lz2_q   <= lz2_d;
      zero2_q <= (x1_q == '0);
    end
  end

  // Stage 3: fine normalize by 4, 2, 1
  logic [63:0] n3_d, n3_q;
  logic [5:0]  lz3_d, lz3_q;
  logic        zero3_q;
  always_comb begin
    n3_d  = n2_q;
    lz3_d = lz2_q;
    if (n3_d[63:60] == '0) begin
      n3_d = n3_d << 4;
      lz3_d[2] = 1'b1;
    end
    if (n3_d[63:62] == '0) begin
      n3_d = n3_d << 2;
      lz3_d[1] = 1'b1;
    end
    if (!n3_d[63]) begin
      n3_d = n3_d << 1;
      lz3_d[0] = 1'b1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      n3_q    <= n3_d;
      lz3_q   <= lz3_d;
      zero3_q <= zero2_q;
    end
  end

  // Stage 4: segment lookup on the top fraction bits
  logic [4:0]  idx4;
  logic [25:0] lo4_d, hi4_d;
  logic [25:0] lo4_q;
  logic [21:0] diff4_q;
  logic [27:0] rem4_q;
  logic [5:0]  lz4_q;
  logic        zero4_q;
  always_comb begin
    idx4  = {1'b0, n3_q[62:59]};
    lo4_d = thc_pkg::ln_tab(idx4);
    hi4_d = thc_pkg::ln_tab(idx4 + 5'd1);
  end
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      lo4_q   <= lo4_d;
      diff4_q <= 22'(hi4_d - lo4_d);
      rem4_q  <= n3_q[58:31];
      lz4_q   <= lz3_q;
      zero4_q <= zero3_q;
    end
  end

  // Stage 5: interpolate and weight the exponent by ln(2)
  logic [49:0]        prod5;
  logic signed [6:0]  pm5;
  logic signed [32:0] pm5_x, t16_x;
  logic [25:0]        ln1p5_q;
  logic signed [32:0] pterm5_q;
  logic               zero5_q;
  always_comb begin
    prod5 = diff4_q * rem4_q;
    pm5   = 7'sd31 - $signed({1'b0, lz4_q});
    pm5_x = {{26{pm5[6]}}, pm5};
    t16_x = $signed({7'b0, thc_pkg::LN_T16});
  end
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      ln1p5_q  <= 26'(lo4_q + {4'b0, prod5[49:28]});
      pterm5_q <= pm5_x * t16_x;
      zero5_q  <= zero4_q;
    end
  end

  // Stage 6: ln(R), split into sign and magnitude
  logic signed [32:0] l6;
  thc_pkg::ln_out_t   o6_q;
  always_comb begin
    l6 = pterm5_q + $signed({7'b0, ln1p5_q});
  end
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      o6_q.neg  <= l6[32];
      o6_q.mag  <= l6[32] ? 31'(-l6) : 31'(l6);
      o6_q.zero <= zero5_q;
    end
  end

  assign out_data_o = o6_q;

endmodule
`default_nettype wire

[rtl/core/thc_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// thc_div: pipelined restoring divider for 10000 * 2^40 / S
// One quotient bit per stage; the remainder stays below the divisor.
// ----------------------------------------------------------------------------
module thc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  thc_pkg::div_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output thc_pkg::div_st_t  out_data_o
);

  localparam int unsigned N = thc_pkg::DIV_STEPS;

  logic [N-1:0]     v_q;
  logic [N-1:0]     en;
  thc_pkg::div_st_t st_q [N];
  thc_pkg::div_st_t prev [N];
  thc_pkg::div_st_t nxt  [N];

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[N-1] = !v_q[N-1] || out_ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < N; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Seed the first step with the top bits of the dividend
  always_comb begin
    prev[0].r    = thc_pkg::DIV_R0;
    prev[0].q    = '0;
    prev[0].s    = in_data_i.s;
    prev[0].zero = in_data_i.zero;
    prev[0].hot  = in_data_i.hot;
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [39:0] t;
    logic [39:0] dv;
    logic        ge;

    if (k > 0) begin : g_link
      assign prev[k] = st_q[k-1];
    end

    // Shift in a zero dividend bit, subtract when the divisor fits
    always_comb begin
      t  = {prev[k].r, 1'b0};
      dv = {1'b0, prev[k].s};
      ge = (t >= dv);
      nxt[k]   = prev[k];
      nxt[k].r = ge ? 39'(t - dv) : t[38:0];
      nxt[k].q = {prev[k].q[21:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) st_q[k] <= nxt[k];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[N-1];
  assign out_data_o  = st_q[N-1];

endmodule
`default_nettype wire

[rtl/core/thermistor_counts_to_celsius_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// thermistor_counts_to_celsius_top: Steinhart-Hart thermistor conversion
// ADC count in, temperature in 0.0001 degC out, with a saturation flag.
// ----------------------------------------------------------------------------
// Fully pipelined: one count is taken every cycle unless the output stalls.
// Stages: 6 log, 6 polynomial, 23 divider, then one output register.
// Valid travels with each stage and a stage moves whenever it is empty or its
// successor moves, so a stalled output fills bubbles and holds every word
// without loss. The user must write registers through the plain write port
// only while no word is in flight; the block does not enforce this. A zero
// resistance reads as absolute zero with the flag set; a sum too small for
// the fit, or a result above 300 degC, reads as 300 degC with the flag set.
module thermistor_counts_to_celsius_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  thc_in_if.sink      in_i,
  thc_out_if.source   out_o
);

  // Configuration registers
  logic [31:0] coef_a_q, coef_b_q, coef_c_q, ohms_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q <= thc_pkg::COEF_A_RST;
      coef_b_q <= thc_pkg::COEF_B_RST;
      coef_c_q <= thc_pkg::COEF_C_RST;
      ohms_q   <= thc_pkg::OHMS_RST;
    end else if (cfg_we_i) begin
      unique case (thc_pkg::cfg_idx_e'(cfg_idx_i))
        thc_pkg::CFG_COEF_A: coef_a_q <= cfg_data_i;
        thc_pkg::CFG_COEF_B: coef_b_q <= cfg_data_i;
        thc_pkg::CFG_COEF_C: coef_c_q <= cfg_data_i;
        thc_pkg::CFG_OHMS:   ohms_q   <= cfg_data_i;
      endcase
    end
  end

  // Log front end
  logic             ln_valid, ln_ready;
  thc_pkg::ln_out_t ln_data;

  thc_ln u_ln (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .count_i     (thc_pkg::COUNT_BITS'(in_i.adc_count)),
    .ohms_i      (ohms_q),
    .out_valid_o (ln_valid),
    .out_ready_i (ln_ready),
    .out_data_o  (ln_data)
  );

  // Polynomial stages
  localparam int unsigned N = 6;
  logic [N-1:0] v_q;
  logic [N-1:0] en;
  logic         div_ready;

  always_comb begin
    en[N-1] = !v_q[N-1] || div_ready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= ln_valid;
      for (int k = 1; k < N; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign ln_ready = en[0];

  // B*L and L^2
  logic [62:0] pb7;
  logic [61:0] pm7;
  logic [36:0] bt7_q;
  logic [35:0] l2_7_q;
  logic [30:0] mag7_q;
  logic        neg7_q, zero7_q;
  always_comb begin
    pb7 = coef_b_q * ln_data.mag;
    pm7 = ln_data.mag * ln_data.mag;
  end
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      bt7_q   <= pb7[62:26];
      l2_7_q  <= pm7[61:26];
      mag7_q  <= ln_data.mag;
      neg7_q  <= ln_data.neg;
      zero7_q <= ln_data.zero;
    end
  end

  // L^3
  logic [66:0] p8;
  logic [40:0] l3_8_q;
  logic [36:0] bt8_q;
  logic        neg8_q, zero8_q;
  always_comb begin
    p8 = l2_7_q * mag7_q;
  end
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      l3_8_q  <= p8[66:26];
      bt8_q   <= bt7_q;
      neg8_q  <= neg7_q;
      zero8_q <= zero7_q;
    end
  end

  // C*L^3 as two partial products
  logic [51:0] ph9_q;
  logic [52:0] pl9_q;
  logic [36:0] bt9_q;
  logic        neg9_q, zero9_q;
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      ph9_q   <= coef_c_q * l3_8_q[40:21];
      pl9_q   <= coef_c_q * l3_8_q[20:0];
      bt9_q   <= bt8_q;
      neg9_q  <= neg8_q;
      zero9_q <= zero8_q;
    end
  end

  // Join the partial products and drop the 2^38 scale
  logic [73:0] full10;
  logic [35:0] ct10_q;
  logic [36:0] bt10_q;
  logic        neg10_q, zero10_q;
  always_comb begin
    full10 = {1'b0, ph9_q, 21'b0} + 74'(pl9_q);
  end
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      ct10_q   <= full10[73:38];
      bt10_q   <= bt9_q;
      neg10_q  <= neg9_q;
      zero10_q <= zero9_q;
    end
  end

  // B*L + C*L^3
  logic [37:0] terms11_q;
  logic        neg11_q, zero11_q;
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      terms11_q <= 38'(bt10_q) + 38'(ct10_q);
      neg11_q   <= neg10_q;
      zero11_q  <= zero10_q;
    end
  end

  // S = A +/- terms; flag a sum too small for the quotient range
  logic signed [39:0] sa12, st12, s12;
  thc_pkg::div_in_t   d12_q;
  always_comb begin
    sa12 = $signed({8'b0, coef_a_q});
    st12 = $signed({2'b0, terms11_q});
    s12  = neg11_q ? (sa12 - st12) : (sa12 + st12);
  end
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      d12_q.s    <= s12[38:0];
      d12_q.hot  <= (s12 <= $signed({1'b0, thc_pkg::DIV_R0}));
      d12_q.zero <= zero11_q;
    end
  end

  // Divider
  logic             dq_valid, dq_ready;
  thc_pkg::div_st_t dq;

  thc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v_q[N-1]),
    .in_ready_o  (div_ready),
    .in_data_i   (d12_q),
    .out_valid_o (dq_valid),
    .out_ready_i (dq_ready),
    .out_data_o  (dq)
  );

  // Output word: round toward zero, offset to Celsius, saturate
  logic               vo_q;
  logic signed [22:0] temp_d, temp_q;
  logic               flag_d, flag_q;
  logic [23:0]        q1;
  always_comb begin
    q1 = 24'(dq.q);
    if ((q1 < thc_pkg::Q_KELVIN) && (dq.r != '0)) q1 = q1 + 24'd1;
    priority if (dq.zero) begin
      temp_d = thc_pkg::TEMP_COLD;
      flag_d = 1'b1;
    end else if (dq.hot || (q1 > thc_pkg::Q_MAX)) begin
      temp_d = thc_pkg::TEMP_HOT;
      flag_d = 1'b1;
    end else begin
      temp_d = $signed(23'(q1 - thc_pkg::Q_KELVIN));
      flag_d = 1'b0;
    end
  end

  assign dq_ready = !vo_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (dq_ready) begin
      vo_q <= dq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dq_ready) begin
      temp_q <= temp_d;
      flag_q <= flag_d;
    end
  end

  assign out_o.valid        = vo_q;
  assign out_o.temp_e4      = temp_q;
  assign out_o.out_of_range = flag_q;

  // Checks on the conversion and the stall chain
  a_flag_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.out_of_range |->
      (out_o.temp_e4 == thc_pkg::TEMP_COLD) || (out_o.temp_e4 == thc_pkg::TEMP_HOT))
    else $error("saturated word carries a non-limit temperature");

  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.out_of_range |->
      (out_o.temp_e4 >= thc_pkg::TEMP_COLD) && (out_o.temp_e4 <= thc_pkg::TEMP_HOT))
    else $error("unflagged temperature outside the output range");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("input stalled while the output is free");

endmodule
`default_nettype wire
